// File: rtl/bmp_rle_stream_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// bmp rle stream decoder assertion macros
// concurrent check helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BMP_RLE_STREAM_DECODER_TOP_ASSERT_SVH
`define BMP_RLE_STREAM_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BRLE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BRLE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/brle_pkg.sv
// ----------------------------------------------------------------------------
// brle_pkg
// shared constants, register indexes and types of the bmp rle decoder
// ----------------------------------------------------------------------------
`default_nettype none

package brle_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int COORD_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);
    localparam logic [3:0]       NIB_MASK  = 4'hF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
        logic [7:0]         span_length;
        logic [7:0]         first_value;
        logic [3:0]         second_value;
        logic               alternate;
        logic               image_done;
    } span_t;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = DIM_W'(1);
            end
            else if (v > MAX_DIM_V)
            begin
                r = MAX_DIM_V;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/bmp_rle_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// bmp_rle_stream_decoder_top
// rle8 / rle4 bitmap stream decoder producing clipped pixel spans
// ----------------------------------------------------------------------------
// The decoder takes one coded byte per cycle on the input channel, sustained
// while no span request waits on a stalled output channel, and gives at most
// one span request per byte on the output channel. A byte passes through an
// input register, one stage of decode logic that updates the column, row and
// escape phase, and a result register. The per-byte rate is set by the update
// of the position registers, which each byte reads and writes once. Bytes that
// write no visible pixel (count bytes, escapes, pad bytes, fully clipped spans)
// leave the pipe without a result and do not wait for the
// output side. A span gives row, first column, pixel count after
// clipping to image_width, a value and, in 4-bit mode, a second nibble with
// alternate set. End-of-bitmap, or a row move reaching image_height, gives a
// single end marker (all fields zero, image_done set); later bytes are
// dropped until one arrives with frame_start set. Configuration registers
// (index 0 rle_mode, 1 image_width, 2 image_height) are written on the cfg
// channel, which is always ready; write them only while the decoder is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_rle_stream_decoder_top
(
    input  wire                              clk,
    input  wire                              rst_n,
    // coded byte channel
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [7:0]                       code_byte,
    input  wire                              frame_start,
    // span channel
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [brle_pkg::COORD_W-1:0]     row,
    output logic [brle_pkg::COORD_W-1:0]     column,
    output logic [7:0]                       span_length,
    output logic [7:0]                       first_value,
    output logic [3:0]                       second_value,
    output logic                             alternate,
    output logic                             image_done,
    // configuration write channel
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [brle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [brle_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import brle_pkg::*;

`include "bmp_rle_stream_decoder_top_assert.svh"

    // decode phase codes
    localparam logic [2:0] PH_COUNT = 3'd0;
    localparam logic [2:0] PH_VALUE = 3'd1;
    localparam logic [2:0] PH_DX    = 3'd2;
    localparam logic [2:0] PH_DY    = 3'd3;
    localparam logic [2:0] PH_ABS   = 3'd4;
    localparam logic [2:0] PH_PAD   = 3'd5;

    // configuration
    logic                  rle_mode_reg;
    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;

    // input stage
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_fs_reg;

    // decode state
    logic [2:0]            phase_reg,         phase_next;
    logic [7:0]            count_hold_reg,    count_hold_next;
    logic [7:0]            delta_x_hold_reg,  delta_x_hold_next;
    logic [7:0]            absolute_left_reg, absolute_left_next;
    logic                  pad_pending_reg,   pad_pending_next;
    logic [DIM_W-1:0]      pos_x_reg,         pos_x_next;
    logic [DIM_W-1:0]      pos_y_reg,         pos_y_next;
    logic                  finished_reg,      finished_next;

    // result stage
    logic                  out_valid_reg;
    span_t                 result_reg;
    span_t                 result_next;
    logic                  has_result;
    logic                  advance;

    // decode temporaries
    logic [DIM_W-1:0]      w;
    logic [DIM_W-1:0]      h;
    logic                  four;
    logic [2:0]            cur_phase;
    logic [7:0]            cur_count;
    logic [7:0]            cur_dx;
    logic [7:0]            cur_left;
    logic                  cur_pad;
    logic [DIM_W-1:0]      cur_x;
    logic [DIM_W-1:0]      cur_y;
    logic                  cur_fin;
    logic                  do_span;
    logic [7:0]            span_npix;
    logic [7:0]            span_v1;
    logic [3:0]            span_v2;
    logic                  span_alt;
    logic                  do_end;
    logic [DIM_W-1:0]      room;
    logic [7:0]            span_len;
    logic [DIM_W:0]        x_sum;
    logic [DIM_W:0]        y_sum;
    logic [8:0]            abs_plus;
    logic [7:0]            abs_npix;

    // ------------------------------------------------------------------------
    // configuration port, never stalls
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_mode_reg     <= 1'b0;
            image_width_reg  <= CFG_DATA_W'(MAX_DIM);
            image_height_reg <= CFG_DATA_W'(MAX_DIM);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RLE_MODE:     rle_mode_reg     <= cfg_data[0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // handshake: a byte with no result never waits on the output side
    // ------------------------------------------------------------------------
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready || !has_result);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= code_byte;
            in_fs_reg   <= frame_start;
        end
    end

    // ------------------------------------------------------------------------
    // decode logic for the byte in the input register
    // ------------------------------------------------------------------------
    always_comb
    begin
        w    = eff_dim(image_width_reg);
        h    = eff_dim(image_height_reg);
        four = rle_mode_reg;

        // frame start clears the frame state ahead of this byte
        if (in_fs_reg)
        begin
            cur_phase = PH_COUNT;
            cur_count = '0;
            cur_dx    = '0;
            cur_left  = '0;
            cur_pad   = 1'b0;
            cur_x     = '0;
            cur_y     = '0;
            cur_fin   = 1'b0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_count = count_hold_reg;
            cur_dx    = delta_x_hold_reg;
            cur_left  = absolute_left_reg;
            cur_pad   = pad_pending_reg;
            cur_x     = pos_x_reg;
            cur_y     = pos_y_reg;
            cur_fin   = finished_reg;
        end

        phase_next         = cur_phase;
        count_hold_next    = cur_count;
        delta_x_hold_next  = cur_dx;
        absolute_left_next = cur_left;
        pad_pending_next   = cur_pad;
        pos_x_next         = cur_x;
        pos_y_next         = cur_y;
        finished_next      = cur_fin;

        do_span   = 1'b0;
        span_npix = '0;
        span_v1   = '0;
        span_v2   = '0;
        span_alt  = 1'b0;
        do_end    = 1'b0;
        x_sum     = '0;
        y_sum     = '0;
        abs_plus  = {1'b0, in_byte_reg} + 9'd1;
        abs_npix  = (cur_left < 8'd2) ? cur_left : 8'd2;

        if (!cur_fin)
        begin
            // width may have shrunk since the last byte
            if (cur_x > w)
            begin
                cur_x      = w;
                pos_x_next = w;
            end

            case (cur_phase)
                PH_COUNT:
                begin
                    count_hold_next = in_byte_reg;
                    phase_next      = PH_VALUE;
                end
                PH_VALUE:
                begin
                    phase_next = PH_COUNT;
                    if (cur_count != '0)
                    begin
                        // encoded run
                        do_span   = 1'b1;
                        span_npix = cur_count;
                        if (four)
                        begin
                            span_v1  = {4'd0, in_byte_reg[7:4]};
                            span_v2  = in_byte_reg[3:0] & NIB_MASK;
                            span_alt = 1'b1;
                        end
                        else
                        begin
                            span_v1 = in_byte_reg;
                        end
                    end
                    else if (in_byte_reg == 8'd0)
                    begin
                        // end of line
                        pos_x_next = '0;
                        y_sum      = {1'b0, cur_y} + (DIM_W+1)'(1);
                        if (y_sum >= {1'b0, h})
                        begin
                            pos_y_next = h;
                            do_end     = 1'b1;
                        end
                        else
                        begin
                            pos_y_next = y_sum[DIM_W-1:0];
                        end
                    end
                    else if (in_byte_reg == 8'd1)
                    begin
                        // end of bitmap
                        do_end = 1'b1;
                    end
                    else if (in_byte_reg == 8'd2)
                    begin
                        phase_next = PH_DX;
                    end
                    else
                    begin
                        // absolute run, pad fixed by the mode at its start
                        absolute_left_next = in_byte_reg;
                        pad_pending_next   = four ? abs_plus[1] : in_byte_reg[0];
                        phase_next         = PH_ABS;
                    end
                end
                PH_DX:
                begin
                    delta_x_hold_next = in_byte_reg;
                    phase_next        = PH_DY;
                end
                PH_DY:
                begin
                    phase_next = PH_COUNT;
                    x_sum      = {1'b0, cur_x} + (DIM_W+1)'(cur_dx);
                    pos_x_next = (x_sum > {1'b0, w}) ? w : x_sum[DIM_W-1:0];
                    y_sum      = {1'b0, cur_y} + (DIM_W+1)'(in_byte_reg);
                    if (y_sum >= {1'b0, h})
                    begin
                        pos_y_next = h;
                        do_end     = 1'b1;
                    end
                    else
                    begin
                        pos_y_next = y_sum[DIM_W-1:0];
                    end
                end
                PH_ABS:
                begin
                    do_span = 1'b1;
                    if (four)
                    begin
                        span_npix = abs_npix;
                        span_v1   = {4'd0, in_byte_reg[7:4]};
                        span_v2   = in_byte_reg[3:0] & NIB_MASK;
                        span_alt  = 1'b1;
                    end
                    else
                    begin
                        span_npix = 8'd1;
                        span_v1   = in_byte_reg;
                    end
                    absolute_left_next = cur_left - span_npix;
                    if (absolute_left_next == '0)
                    begin
                        phase_next = cur_pad ? PH_PAD : PH_COUNT;
                    end
                end
                PH_PAD:
                begin
                    pad_pending_next = 1'b0;
                    phase_next       = PH_COUNT;
                end
                default:
                begin
                    phase_next = PH_COUNT;
                end
            endcase
        end

        // span clipping against the row width
        room     = w - cur_x;
        span_len = ({5'd0, span_npix} < room) ? span_npix : room[7:0];
        if (do_span)
        begin
            x_sum      = {1'b0, cur_x} + (DIM_W+1)'(span_npix);
            pos_x_next = (x_sum > {1'b0, w}) ? w : x_sum[DIM_W-1:0];
        end

        result_next = '0;
        has_result  = 1'b0;
        if (do_end)
        begin
            finished_next          = 1'b1;
            phase_next             = PH_COUNT;
            result_next.image_done = 1'b1;
            has_result             = 1'b1;
        end
        else if (do_span && (span_len != '0))
        begin
            result_next.row          = cur_y[COORD_W-1:0];
            result_next.column       = cur_x[COORD_W-1:0];
            result_next.span_length  = span_len;
            result_next.first_value  = span_v1;
            result_next.second_value = span_v2;
            result_next.alternate    = span_alt;
            has_result               = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_COUNT;
            count_hold_reg    <= '0;
            delta_x_hold_reg  <= '0;
            absolute_left_reg <= '0;
            pad_pending_reg   <= 1'b0;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            finished_reg      <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            count_hold_reg    <= count_hold_next;
            delta_x_hold_reg  <= delta_x_hold_next;
            absolute_left_reg <= absolute_left_next;
            pad_pending_reg   <= pad_pending_next;
            pos_x_reg         <= pos_x_next;
            pos_y_reg         <= pos_y_next;
            finished_reg      <= finished_next;
        end
    end

    // ------------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign row          = result_reg.row;
    assign column       = result_reg.column;
    assign span_length  = result_reg.span_length;
    assign first_value  = result_reg.first_value;
    assign second_value = result_reg.second_value;
    assign alternate    = result_reg.alternate;
    assign image_done   = result_reg.image_done;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `BRLE_ASSERT_IMPL(a_span_nonempty, clk, rst_n,
        out_valid_reg && !result_reg.image_done, result_reg.span_length != '0,
        "pixel span request with zero length")
    `BRLE_ASSERT_IMPL(a_phase_legal, clk, rst_n,
        1'b1, phase_reg <= PH_PAD,
        "decode phase out of range")
    `BRLE_ASSERT_IMPL(a_pos_bounded, clk, rst_n,
        1'b1, (pos_x_reg <= MAX_DIM_V) && (pos_y_reg <= MAX_DIM_V),
        "position beyond the largest image")
    `BRLE_ASSERT_IMPL(a_pad_in_abs, clk, rst_n,
        pad_pending_reg, (phase_reg == PH_ABS) || (phase_reg == PH_PAD),
        "pad pending outside an absolute run")

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bmp rle8 / rle4 stream decoder: a byte-level
// predictor tracks phase, column and row and queues the span requests that
// every accepted code byte should produce; each span request is compared field
// by field with the oldest queued one, mostly under random stalls on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import brle_pkg::*;

    // timing of the run
    localparam int DRAIN_CYCLES = 8;          // pipe is two deep, leave margin
    localparam int LIMIT_NS     = 1_000_000;  // hard stop, far above a clean run
    localparam int PHASE_BYTES  = 215;        // at least this many decoded bytes per random phase
    localparam int PHASE_SPANS  = 12;         // at least this many span requests per random phase

    // escape codes of the coded stream
    localparam logic [7:0] ESC_PREFIX        = 8'h00;
    localparam logic [7:0] ESC_END_OF_LINE   = 8'h00;
    localparam logic [7:0] ESC_END_OF_BITMAP = 8'h01;
    localparam logic [7:0] ESC_DELTA         = 8'h02;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // decode phase of the predictor
    typedef enum logic [2:0]
    {
        WANT_COUNT,
        WANT_VALUE,
        WANT_DX,
        WANT_DY,
        IN_LITERALS,
        WANT_PAD
    } dec_phase_t;

    // one row of the directed table: a register setting or a code byte
    typedef struct packed
    {
        bit                  is_cfg;
        logic                fs;
        logic [7:0]          code;
        bit                  typed;
        span_t               want;
        logic                mode;
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
    } stim_row_t;

    // clock, reset and block inputs, all known from time zero
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic [7:0]            code_byte   = 8'h00;
    logic                  frame_start = 1'b0;
    logic                  out_ready   = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // block outputs
    logic                  in_ready;
    logic                  out_valid;
    logic [COORD_W-1:0]    row;
    logic [COORD_W-1:0]    column;
    logic [7:0]            span_length;
    logic [7:0]            first_value;
    logic [3:0]            second_value;
    logic                  alternate;
    logic                  image_done;
    logic                  cfg_ready;

    // predictor registers
    logic                  mode_4bit;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;

    // predictor decode state; column and row kept wide enough to saturate
    dec_phase_t            dec_phase;
    logic [7:0]            run_count;
    logic [7:0]            skip_x;
    logic [7:0]            lit_left;
    logic                  pad_due;
    int                    cur_x;
    int                    cur_y;
    logic                  ended;

    // span requests still owed by the block, oldest first
    span_t                 spans_due[$];
    stim_row_t             directed[$];

    // stall odds, in percent per cycle
    int                    src_idle_pct  = 0;
    int                    sink_idle_pct = 0;

    // bookkeeping
    int                    fail_count       = 0;
    int                    bytes_sent       = 0;
    int                    bytes_live       = 0;
    int                    spans_expected   = 0;
    int                    spans_checked    = 0;
    int                    settings_applied = 0;

    bmp_rle_stream_decoder_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .code_byte    (code_byte),
        .frame_start  (frame_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .row          (row),
        .column       (column),
        .span_length  (span_length),
        .first_value  (first_value),
        .second_value (second_value),
        .alternate    (alternate),
        .image_done   (image_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 2 ns clock
    always #1 clk = ~clk;

    // receiver side: stall at random, odds set per phase
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // zero acts as one, anything past the maximum acts as the maximum
    function automatic int clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    // position, phase and holds back to the top left of a fresh image
    function automatic void start_frame();
        dec_phase = WANT_COUNT;
        run_count = '0;
        skip_x    = '0;
        lit_left  = '0;
        pad_due   = 1'b0;
        cur_x     = 0;
        cur_y     = 0;
        ended     = 1'b0;
    endfunction

    function automatic void reset_model();
        mode_4bit  = 1'b0;
        width_reg  = DIM_W'(MAX_DIM);
        height_reg = DIM_W'(MAX_DIM);
        start_frame();
    endfunction

    // end marker: all fields zero but image_done, decoding stops
    function automatic void end_marker(output bit hit, output span_t s);
        ended     = 1'b1;
        dec_phase = WANT_COUNT;
        s         = '0;
        s.image_done = 1'b1;
        hit       = 1'b1;
    endfunction

    // npix pixels at the current column, clipped at the width
    function automatic void write_pixels(input int npix, input logic [7:0] v1,
                                         input logic [3:0] v2, input logic alt,
                                         input int w, output bit hit,
                                         output span_t s);
        int room;
        int len;
        int col;
        room  = w - cur_x;
        len   = (npix < room) ? npix : room;
        col   = cur_x;
        cur_x = (cur_x + npix > w) ? w : cur_x + npix;
        s     = '0;
        hit   = (len != 0);
        if (hit)
        begin
            s.row          = COORD_W'(cur_y);
            s.column       = COORD_W'(col);
            s.span_length  = 8'(len);
            s.first_value  = v1;
            s.second_value = v2;
            s.alternate    = alt;
        end
    endfunction

    // one code byte in; live is low when a finished image drops the byte
    function automatic void decode_byte(input logic [7:0] b, input logic fs,
                                        output bit live, output bit hit,
                                        output span_t s);
        int   w;
        int   h;
        int   npix;
        logic four;
        w    = clamp_dim(width_reg);
        h    = clamp_dim(height_reg);
        four = mode_4bit;
        hit  = 1'b0;
        s    = '0;
        if (fs)
        begin
            start_frame();
        end
        live = !ended;
        if (ended)
        begin
            return;
        end
        if (cur_x > w)
        begin
            cur_x = w;
        end
        case (dec_phase)
            WANT_COUNT:
            begin
                run_count = b;
                dec_phase = WANT_VALUE;
            end
            WANT_VALUE:
            begin
                dec_phase = WANT_COUNT;
                if (run_count != 8'h00)
                begin
                    if (four)
                    begin
                        write_pixels(int'(run_count), {4'h0, b[7:4]}, b[3:0], 1'b1,
                                     w, hit, s);
                    end
                    else
                    begin
                        write_pixels(int'(run_count), b, 4'h0, 1'b0, w, hit, s);
                    end
                end
                else if (b == ESC_END_OF_LINE)
                begin
                    cur_x = 0;
                    cur_y++;
                    if (cur_y >= h)
                    begin
                        cur_y = h;
                        end_marker(hit, s);
                    end
                end
                else if (b == ESC_END_OF_BITMAP)
                begin
                    end_marker(hit, s);
                end
                else if (b == ESC_DELTA)
                begin
                    dec_phase = WANT_DX;
                end
                else
                begin
                    // absolute run; its pad is fixed here, whatever the mode later
                    lit_left  = b;
                    pad_due   = four ? ((((int'(b) + 1) >> 1) % 2) == 1) : b[0];
                    dec_phase = IN_LITERALS;
                end
            end
            WANT_DX:
            begin
                skip_x    = b;
                dec_phase = WANT_DY;
            end
            WANT_DY:
            begin
                dec_phase = WANT_COUNT;
                cur_x = (cur_x + int'(skip_x) > w) ? w : cur_x + int'(skip_x);
                cur_y = cur_y + int'(b);
                if (cur_y >= h)
                begin
                    cur_y = h;
                    end_marker(hit, s);
                end
            end
            IN_LITERALS:
            begin
                if (four)
                begin
                    npix = (lit_left < 8'd2) ? int'(lit_left) : 2;
                    write_pixels(npix, {4'h0, b[7:4]}, b[3:0], 1'b1, w, hit, s);
                end
                else
                begin
                    npix = 1;
                    write_pixels(1, b, 4'h0, 1'b0, w, hit, s);
                end
                lit_left = lit_left - 8'(npix);
                if (lit_left == 8'h00)
                begin
                    dec_phase = pad_due ? WANT_PAD : WANT_COUNT;
                end
            end
            WANT_PAD:
            begin
                pad_due   = 1'b0;
                dec_phase = WANT_COUNT;
            end
            default:
            begin
                dec_phase = WANT_COUNT;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic span_t mk_span(input int r, input int c, input int len,
                                      input int v1, input int v2, input int alt,
                                      input int done);
        span_t s;
        s.row          = COORD_W'(r);
        s.column       = COORD_W'(c);
        s.span_length  = 8'(len);
        s.first_value  = 8'(v1);
        s.second_value = 4'(v2);
        s.alternate    = 1'(alt);
        s.image_done   = 1'(done);
        return s;
    endfunction

    function automatic stim_row_t byte_row(input logic fs, input logic [7:0] code);
        stim_row_t r;
        r      = '0;
        r.fs   = fs;
        r.code = code;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic fs, input logic [7:0] code,
                                            input span_t want);
        stim_row_t r;
        r       = byte_row(fs, code);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic mode, input int w, input int h);
        stim_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.mode   = mode;
        r.w      = DIM_W'(w);
        r.h      = DIM_W'(h);
        return r;
    endfunction

    // one byte request; a typed expectation replaces the predicted one
    task automatic send_byte(input logic [7:0] b, input logic fs, input bit typed,
                             input span_t typed_s);
        bit    live;
        bit    hit;
        span_t s;
        // hold-off of random length before the request goes up
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct)
            begin
                @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        code_byte   <= b;
        frame_start <= fs;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        decode_byte(b, fs, live, hit, s);
        bytes_sent++;
        if (live)
        begin
            bytes_live++;
        end
        if (typed)
        begin
            hit = 1'b1;
            s   = typed_s;
        end
        if (hit)
        begin
            spans_due.push_back(s);
            spans_expected++;
        end
    endtask

    // drop valid, let every owed span drain, then let the pipe empty out
    task automatic settle();
        in_valid <= 1'b0;
        while (spans_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write; cfg_valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_RLE_MODE:     mode_4bit  = data[0];
            CFG_IMAGE_WIDTH:  width_reg  = data;
            CFG_IMAGE_HEIGHT: height_reg = data;
            default:          ;
        endcase
    endtask

    // new register setting, only once the decoder has gone quiet
    task automatic apply_settings(input logic mode, input logic [DIM_W-1:0] w,
                                  input logic [DIM_W-1:0] h);
        settle();
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        write_reg(CFG_RLE_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // one well-formed command with random content, now and then noise
    task automatic emit_command();
        logic [7:0] seq[$];
        int         pick;
        int         n;
        int         nbytes;
        int         i;
        int         dy;
        bit         fresh;
        bit         noisy;
        logic       fs;
        // a finished image is always followed by a new frame
        fresh = ended || ($urandom_range(0, 99) < 3);
        noisy = 1'b0;
        pick  = $urandom_range(0, 99);
        if (pick < 42)
        begin
            // encoded run, mostly short
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
            seq.push_back(8'(n));
            seq.push_back(8'($urandom));
        end
        else if (pick < 52)
        begin
            seq.push_back(ESC_PREFIX);
            seq.push_back(ESC_END_OF_LINE);
        end
        else if (pick < 62)
        begin
            // delta, mostly along the row, now and then far down
            n  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
            dy = $urandom_range(0, 99);
            dy = (dy < 55) ? 0 : (dy < 85) ? $urandom_range(1, 2) : $urandom_range(0, 255);
            seq.push_back(ESC_PREFIX);
            seq.push_back(ESC_DELTA);
            seq.push_back(8'(n));
            seq.push_back(8'(dy));
        end
        else if (pick < 82)
        begin
            // absolute run with its literal bytes and word-alignment pad
            n      = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 255)
                                                  : $urandom_range(3, 24);
            nbytes = mode_4bit ? (n + 1) / 2 : n;
            seq.push_back(ESC_PREFIX);
            seq.push_back(8'(n));
            for (i = 0; i < nbytes; i++)
            begin
                seq.push_back(8'($urandom));
            end
            if (nbytes % 2 == 1)
            begin
                seq.push_back(8'($urandom));
            end
        end
        else if (pick < 85)
        begin
            seq.push_back(ESC_PREFIX);
            seq.push_back(ESC_END_OF_BITMAP);
        end
        else
        begin
            // broken sequence: stray bytes, sometimes with a frame start
            noisy = 1'b1;
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
            begin
                seq.push_back(8'($urandom));
            end
        end
        for (i = 0; i < seq.size(); i++)
        begin
            fs = ((i == 0) && fresh) || (noisy && ($urandom_range(0, 7) == 0));
            send_byte(seq[i], fs, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] expv,
                                        input logic [31:0] actv);
        if (actv !== expv)
        begin
            $error("%s: expected %0d, actual %0d", name, expv, actv);
            fail_count++;
        end
    endfunction

    // every accepted span request against the oldest one owed
    always @(posedge clk)
    begin : span_watch
        span_t got;
        span_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {row, column, span_length, first_value, second_value,
                   alternate, image_done};
            if (spans_due.size() == 0)
            begin
                $error("span request with none owed: row %0d column %0d length %0d",
                       row, column, span_length);
                fail_count++;
            end
            else
            begin
                want = spans_due.pop_front();
                check_field("row", 32'(want.row), 32'(got.row));
                check_field("column", 32'(want.column), 32'(got.column));
                check_field("span_length", 32'(want.span_length), 32'(got.span_length));
                check_field("first_value", 32'(want.first_value), 32'(got.first_value));
                check_field("second_value", 32'(want.second_value),
                            32'(got.second_value));
                check_field("alternate", 32'(want.alternate), 32'(got.alternate));
                check_field("image_done", 32'(want.image_done), 32'(got.image_done));
                spans_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------------

    // hard stop in case the decoder hangs
    initial
    begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int        k;
        int        p;
        int        live_mark;
        int        spans_mark;
        stim_row_t r;

        reset_model();

        // reset values: 8-bit coding, 4096 x 4096
        // longest run, value read off at a glance
        directed.push_back(byte_row(1'b1, 8'd255));
        directed.push_back(typed_row(1'b0, 8'hAB, mk_span(0, 0, 255, 'hAB, 0, 0, 0)));
        // widest delta along the row
        directed.push_back(byte_row(1'b0, ESC_PREFIX));
        directed.push_back(byte_row(1'b0, ESC_DELTA));
        directed.push_back(byte_row(1'b0, 8'd255));
        directed.push_back(byte_row(1'b0, 8'd0));
        // end-of-bitmap gives the end marker, the next byte is dropped
        directed.push_back(byte_row(1'b0, ESC_PREFIX));
        directed.push_back(typed_row(1'b0, ESC_END_OF_BITMAP, mk_span(0, 0, 0, 0, 0, 0, 1)));
        directed.push_back(byte_row(1'b0, 8'h77));
        // 4-bit coding, narrow and short image
        directed.push_back(cfg_row(1'b1, 16, 2));
        // absolute run of three nibbles: no pad in 4-bit coding
        directed.push_back(byte_row(1'b1, ESC_PREFIX));
        directed.push_back(byte_row(1'b0, 8'd3));
        directed.push_back(typed_row(1'b0, 8'hFF, mk_span(0, 0, 2, 'hF, 'hF, 1, 0)));
        // mode flips inside the run; the pad chosen at the start still holds
        directed.push_back(cfg_row(1'b0, 16, 2));
        directed.push_back(typed_row(1'b0, 8'h00, mk_span(0, 2, 1, 0, 0, 0, 0)));
        // long run clipped at the width
        directed.push_back(byte_row(1'b0, 8'd255));
        directed.push_back(typed_row(1'b0, 8'h3C, mk_span(0, 3, 13, 'h3C, 0, 0, 0)));
        // two end-of-lines reach the height
        directed.push_back(byte_row(1'b0, ESC_PREFIX));
        directed.push_back(byte_row(1'b0, ESC_END_OF_LINE));
        directed.push_back(byte_row(1'b0, ESC_PREFIX));
        directed.push_back(typed_row(1'b0, ESC_END_OF_LINE, mk_span(0, 0, 0, 0, 0, 0, 1)));

        // reset held low, then released once
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under the first stall mix
        src_idle_pct  = 31;
        sink_idle_pct = 55;
        for (k = 0; k < directed.size(); k++)
        begin
            r = directed[k];
            if (r.is_cfg)
            begin
                apply_settings(r.mode, r.w, r.h);
            end
            else
            begin
                send_byte(r.code, r.fs, r.typed, r.want);
            end
        end

        // random phases: two per stall mix, last two with no stalls at all
        for (p = 0; p < 6; p++)
        begin
            case (p)
                0: apply_settings(1'b0, 13'd100, 13'd20);
                1: apply_settings(1'b1, 13'd37, 13'd8191);   // height past the maximum
                2: apply_settings(1'b1, 13'd4096, 13'd1);    // every row move ends
                3: apply_settings(1'b0, 13'd0, 13'd0);       // zero acts as one
                4: apply_settings(1'b0, 13'd8191, 13'd4096); // width past the maximum
                default: apply_settings(1'b1, 13'd4095, 13'd50);
            endcase
            case (p / 2)
                0:
                begin
                    src_idle_pct  = 31;
                    sink_idle_pct = 55;
                end
                1:
                begin
                    src_idle_pct  = 55;
                    sink_idle_pct = 31;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            live_mark  = bytes_live;
            spans_mark = spans_expected;
            while ((bytes_live - live_mark < PHASE_BYTES) ||
                   (spans_expected - spans_mark < PHASE_SPANS))
            begin
                emit_command();
            end
        end

        // drain what is still owed, then let the pipe empty out
        settle();

        $display("%0d code bytes sent, %0d decoded, %0d span requests checked",
                 bytes_sent, bytes_live, spans_checked);
        $display("both coding modes, %0d register settings, dimensions zero to past max",
                 settings_applied);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
